@@ rtl/apwu_pkg.sv @@
// Package: shared widths, register indexes and configuration type for the angle PID unit.
`timescale 1ns / 1ps

package apwu_pkg;

   localparam int ANGLE_W   = 13;
   localparam int ERR_W     = 14;
   localparam int GAIN_W    = 16;
   localparam int LIM_W     = 15;
   localparam int DRIVE_W   = 16;
   localparam int ACC_W     = 24;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [LIM_W-1:0] OUTPUT_LIMIT_RESET = 15'd320;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN        = 3'd0,
      CSR_KI_GAIN        = 3'd1,
      CSR_KD_GAIN        = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp_gain;
      logic signed [GAIN_W-1:0] ki_gain;
      logic signed [GAIN_W-1:0] kd_gain;
      logic [LIM_W-1:0]         integral_limit;
      logic [LIM_W-1:0]         output_limit;
   } cfg_type;

endpackage

@@ rtl/apwu_if.sv @@
// Interfaces: request and response channels of the angle PID unit.
`timescale 1ns / 1ps

interface apwu_req_if;
   import apwu_pkg::*;

   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] measured_angle;
   logic [ANGLE_W-1:0] setpoint_angle;

   modport source (output valid, output measured_angle, output setpoint_angle, input ready);
   modport sink   (input valid, input measured_angle, input setpoint_angle, output ready);
endinterface

interface apwu_rsp_if;
   import apwu_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

@@ rtl/apwu_wrap.sv @@
// Angle error: target minus measured, wrapped to the short way around one turn.
`timescale 1ns / 1ps

module apwu_wrap #(
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic [apwu_pkg::ANGLE_W-1:0]      measured_angle,
   input  logic [apwu_pkg::ANGLE_W-1:0]      setpoint_angle,
   output logic signed [apwu_pkg::ERR_W-1:0] err
);
   import apwu_pkg::*;

   localparam int TurnW = $clog2(COUNTS_PER_TURN) + 2;
   localparam int DiffW = (TurnW > ANGLE_W + 2) ? TurnW : ANGLE_W + 2;
   localparam logic signed [DiffW-1:0] Turn = DiffW'(COUNTS_PER_TURN);
   localparam logic signed [DiffW-1:0] Half = DiffW'(COUNTS_PER_TURN / 2);

   logic signed [DiffW-1:0] diff;
   logic signed [DiffW-1:0] wrapped;

   assign diff = $signed(DiffW'(setpoint_angle)) - $signed(DiffW'(measured_angle));

   always_comb begin
      if (diff >= Half) begin
         wrapped = diff - Turn;
      end else if (diff <= -Half) begin
         wrapped = diff + Turn;
      end else begin
         wrapped = diff;
      end
   end

   assign err = wrapped[ERR_W-1:0];

endmodule

@@ rtl/apwu_law.sv @@
// Control law: P, clamped I and D terms, integral and previous-error state, output clamp.
`timescale 1ns / 1ps

module apwu_law (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  apwu_pkg::cfg_type                   cfg,
   input  logic signed [apwu_pkg::ERR_W-1:0]   err,
   output logic signed [apwu_pkg::DRIVE_W-1:0] drive
);
   import apwu_pkg::*;

   localparam int PW   = GAIN_W + ERR_W;
   localparam int DW   = GAIN_W + ERR_W + 1;
   localparam int SUMW = 32;
   localparam int RESW = SUMW - 8;

   logic signed [ERR_W-1:0]  prev_error_ff;
   logic signed [ERR_W-1:0]  prev_error_in;
   logic signed [ACC_W-1:0]  integral_acc_ff;
   logic signed [ACC_W-1:0]  integral_acc_in;

   logic signed [PW-1:0]     prod_p;
   logic signed [PW-1:0]     prod_i;
   logic signed [ERR_W:0]    delta;
   logic signed [DW-1:0]     prod_d;
   logic signed [SUMW-1:0]   acc_sum;
   logic signed [SUMW-1:0]   ilim;
   logic signed [SUMW-1:0]   acc_clamped;
   logic signed [SUMW-1:0]   total;
   logic signed [RESW-1:0]   shifted;
   logic signed [RESW-1:0]   olim;
   logic signed [RESW-1:0]   res;

   assign prod_p = PW'(cfg.kp_gain) * PW'(err);
   assign prod_i = PW'(cfg.ki_gain) * PW'(err);
   assign delta  = (ERR_W + 1)'(err) - (ERR_W + 1)'(prev_error_ff);
   assign prod_d = DW'(cfg.kd_gain) * DW'(delta);

   assign ilim    = $signed({{(SUMW - LIM_W - 8){1'b0}}, cfg.integral_limit, 8'b0});
   assign acc_sum = SUMW'(integral_acc_ff) + SUMW'(prod_i);

   always_comb begin
      if (acc_sum > ilim) begin
         acc_clamped = ilim;
      end else if (acc_sum < -ilim) begin
         acc_clamped = -ilim;
      end else begin
         acc_clamped = acc_sum;
      end
   end

   assign integral_acc_in = acc_clamped[ACC_W-1:0];
   assign prev_error_in   = err;

   assign total   = SUMW'(prod_p) + acc_clamped + SUMW'(prod_d);
   assign shifted = total[SUMW-1:8];
   assign olim    = $signed({{(RESW - LIM_W){1'b0}}, cfg.output_limit});

   always_comb begin
      if (shifted > olim) begin
         res = olim;
      end else if (shifted < -olim) begin
         res = -olim;
      end else begin
         res = shifted;
      end
   end

   assign drive = res[DRIVE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff   <= '0;
         integral_acc_ff <= '0;
      end else if (advance) begin
         prev_error_ff   <= prev_error_in;
         integral_acc_ff <= integral_acc_in;
      end
   end

endmodule

@@ rtl/angle_pid_wraparound_unit.sv @@
// Top level: angle PID controller with turn wraparound and integral clamp.
//
// Usage:
//   req_ch carries one beat per sample: measured_angle and setpoint_angle, encoder
//   counts on one turn. rsp_ch returns one beat per request: drive, the PID output
//   clamped to +/- output_limit. Both channels use valid/ready; a beat moves on a
//   rising edge with valid and ready high.
//   csr_we/csr_index/csr_wdata write the gains and limits (index 0..4); indexes
//   beyond 4 are ignored. Write them only while no beat is in flight.
// Flow:
//   A request beat lands in the input register at its accepting edge; the control
//   law loads the output register when the beat advances, and drive waits there
//   until rsp_ch.ready is high. One beat per cycle is sustained while rsp_ch.ready
//   stays high; integral and previous error update with each advanced beat.
// Reset:
//   Synchronous, active high. Clears both stages, the integral, the previous
//   error and the gains; output_limit returns to 320.
// Stall:
//   While rsp_ch.ready is low the output register holds its beat; the input
//   register still fills, and req_ch.ready drops once both stages are full.
`timescale 1ns / 1ps

module angle_pid_wraparound_unit #(
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic                              clock,
   input  logic                              reset,
   apwu_req_if.sink                          req_ch,
   apwu_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [apwu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [apwu_pkg::CSR_W-1:0]        csr_wdata
);
   import apwu_pkg::*;

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [ANGLE_W-1:0]        meas_ff;
   logic [ANGLE_W-1:0]        targ_ff;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic signed [DRIVE_W-1:0] drive_ff;

   logic                      advance;
   logic                      accept;
   logic signed [ERR_W-1:0]   err;
   logic signed [DRIVE_W-1:0] drive_next;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.drive = drive_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP_GAIN:        cfg_in.kp_gain        = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_KI_GAIN:        cfg_in.ki_gain        = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_KD_GAIN:        cfg_in.kd_gain        = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[LIM_W-1:0];
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_wdata[LIM_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   apwu_wrap #(
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_wrap (
      .measured_angle (meas_ff),
      .setpoint_angle (targ_ff),
      .err            (err)
   );

   apwu_law u_law (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .err     (err),
      .drive   (drive_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain        <= '0;
         cfg_ff.ki_gain        <= '0;
         cfg_ff.kd_gain        <= '0;
         cfg_ff.integral_limit <= '0;
         cfg_ff.output_limit   <= OUTPUT_LIMIT_RESET;
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meas_ff <= req_ch.measured_angle;
         targ_ff <= req_ch.setpoint_angle;
      end
      if (advance) begin
         drive_ff <= drive_next;
      end
   end

endmodule

@@ rtl/apwu_checker.sv @@
// Checker: port-level assertions for the angle PID unit, bound to the top level.
`timescale 1ns / 1ps

module apwu_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [apwu_pkg::DRIVE_W-1:0] rsp_drive
);
   import apwu_pkg::*;

   localparam logic signed [DRIVE_W-1:0] DriveMin = {1'b1, {(DRIVE_W - 1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive != DriveMin)
      else $error("drive outside symmetric clamp");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("rsp beat missing two cycles after request");

endmodule

bind angle_pid_wraparound_unit apwu_checker u_apwu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_drive (rsp_ch.drive)
);
